/* hw/rtl/csde_pkg.sv */
// ----------------------------------------------------------------------------
// csde_pkg
// Shared types, codes and constants of the coupled SDE step core.
// ----------------------------------------------------------------------------
package csde_pkg;

  // item kinds as the front end classifies them
  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_STEP  = 1'b1
  } csde_item_kind_t;

  typedef struct packed {
    csde_item_kind_t    kind;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [63:0]        gen_x_word0;
    logic [63:0]        gen_x_word1;
    logic [63:0]        gen_y_word0;
    logic [63:0]        gen_y_word1;
  } csde_item_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KAPPA_X     = 3'd0,
    CFG_KAPPA_Y     = 3'd1,
    CFG_SIGMA_X     = 3'd2,
    CFG_SIGMA_Y     = 3'd3,
    CFG_INV_EPSILON = 3'd4,
    CFG_STEP_H      = 3'd5,
    CFG_DRIFT_MODE  = 3'd6
  } csde_cfg_index_t;

  typedef struct packed {
    logic [31:0] kappa_x;
    logic [31:0] kappa_y;
    logic [31:0] sigma_x;
    logic [31:0] sigma_y;
    logic [31:0] inv_epsilon;
    logic [31:0] step_h;
    logic        drift_mode;
  } csde_cfg_t;

  localparam logic [31:0] RATE_RESET   = 32'd65536;
  localparam logic [31:0] STEP_H_RESET = 32'd42949673;

  // shared multiplier request / response
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
  } csde_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
  } csde_mul_rsp_t;

  // shared square root request / response
  typedef struct packed {
    logic        start;
    logic [63:0] v;
  } csde_sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } csde_sqrt_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQH,
    ST_SQE,
    ST_BX0,
    ST_BX1,
    ST_BX2,
    ST_BY,
    ST_GEN,
    ST_LOG,
    ST_G,
    ST_ROOT,
    ST_Z,
    ST_POLY,
    ST_PX,
    ST_N,
    ST_TX0,
    ST_TX1,
    ST_TX2,
    ST_TX3,
    ST_TX4,
    ST_TY0,
    ST_TY1,
    ST_TY2,
    ST_UPD,
    ST_OUT
  } csde_state_t;

  localparam logic [63:0]        PROD_LIMIT  = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
  localparam logic signed [63:0] TWO_LN2_Q30 = 64'sd1488522236;
  localparam logic [5:0]         SH_Q24      = 6'd24;
  localparam logic [5:0]         SH_Q30      = 6'd30;
  localparam logic [5:0]         SH_Q32      = 6'd32;
  localparam logic [4:0]         LOG_LAST    = 5'd23;
  localparam logic [4:0]         SQRT_LAST   = 5'd31;
  localparam logic [4:0]         POLY_TOP    = 5'd4;

  // odd polynomial of sin(pi/2 t), Q30
  localparam logic signed [63:0] SIN_COEF [6] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306,
    -64'sd5026995, 64'sd172272, -64'sd3864
  };

endpackage

/* hw/rtl/csde_if.sv */
// ----------------------------------------------------------------------------
// csde channel interfaces
// Command, result and configuration channels, valid/ready.
// ----------------------------------------------------------------------------
interface csde_cmd_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [63:0]        gen_x_word0;
  logic [63:0]        gen_x_word1;
  logic [63:0]        gen_y_word0;
  logic [63:0]        gen_y_word1;
  modport source (output valid, opcode, start_x, start_y, gen_x_word0, gen_x_word1,
                  gen_y_word0, gen_y_word1, input ready);
  modport sink (input valid, opcode, start_x, start_y, gen_x_word0, gen_x_word1,
                gen_y_word0, gen_y_word1, output ready);
endinterface

interface csde_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  modport source (output valid, x_out, y_out, input ready);
  modport sink (input valid, x_out, y_out, output ready);
endinterface

interface csde_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/csde_front.sv */
// ----------------------------------------------------------------------------
// csde_front
// Accepts command items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module csde_front import csde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  csde_cmd_if.sink   cmd,
  output logic       q_valid,
  input  logic       q_ready,
  output csde_item_t q_item
);

  csde_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  csde_item_t incoming;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slot[rd_ptr];

  always_comb begin
    incoming.kind        = cmd.opcode ? ITEM_STEP : ITEM_START;
    incoming.start_x     = cmd.start_x;
    incoming.start_y     = cmd.start_y;
    incoming.gen_x_word0 = cmd.gen_x_word0;
    incoming.gen_x_word1 = cmd.gen_x_word1;
    incoming.gen_y_word0 = cmd.gen_y_word0;
    incoming.gen_y_word1 = cmd.gen_y_word1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

endmodule

/* hw/rtl/csde_mul.sv */
// ----------------------------------------------------------------------------
// csde_mul
// Shared signed multiply with truncating shift and saturation to 2^61,
// built from four 32x32 partial products over successive cycles.
// ----------------------------------------------------------------------------
module csde_mul import csde_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  csde_mul_req_t req,
  output csde_mul_rsp_t rsp
);

  logic [63:0]        ma;
  logic [63:0]        mb;
  logic               neg;
  logic [5:0]         sh;
  logic [127:0]       acc;
  logic [63:0]        prod;
  logic [2:0]         cnt;
  logic               running;
  logic               done;
  logic signed [63:0] result;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [127:0] term;
  logic [127:0] shifted;
  logic [63:0]  mag;

  assign pa = cnt[1] ? ma[63:32] : ma[31:0];
  assign pb = cnt[0] ? mb[63:32] : mb[31:0];

  // cnt names the partial product just registered, one step behind
  always_comb begin
    case (cnt)
      3'd1:    term = {64'd0, prod};
      3'd2:    term = {32'd0, prod, 32'd0};
      3'd3:    term = {32'd0, prod, 32'd0};
      3'd4:    term = {prod, 64'd0};
      default: term = 128'd0;
    endcase
  end

  always_comb begin
    shifted = acc >> sh;
    if ((shifted[127:64] != 64'd0) || (shifted[63:0] > PROD_LIMIT)) begin
      mag = PROD_LIMIT;
    end else begin
      mag = shifted[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= 3'd0;
    end else begin
      done <= !req.start && running && (cnt == 3'd5);
      if (req.start) begin
        running <= 1'b1;
        cnt     <= 3'd0;
      end else if (running) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ma  <= req.a[63] ? (64'd0 - 64'(req.a)) : 64'(req.a);
      mb  <= req.b[63] ? (64'd0 - 64'(req.b)) : 64'(req.b);
      neg <= req.a[63] ^ req.b[63];
      sh  <= req.sh;
      acc <= 128'd0;
    end else if (running) begin
      if (cnt < 3'd4) begin
        prod <= pa * pb;
      end
      acc <= acc + term;
      if (cnt == 3'd5) begin
        result <= neg ? -$signed(mag) : $signed(mag);
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

/* hw/rtl/csde_sqrt.sv */
// ----------------------------------------------------------------------------
// csde_sqrt
// Shared integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module csde_sqrt import csde_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  csde_sqrt_req_t req,
  output csde_sqrt_rsp_t rsp
);

  logic [63:0] rem;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        running;
  logic        done;
  logic [63:0] trial;
  logic        fits;

  assign trial = root + bitv;
  assign fits  = (rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= 5'd0;
    end else begin
      done <= !req.start && running && (cnt == SQRT_LAST);
      if (req.start) begin
        running <= 1'b1;
        cnt     <= 5'd0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == SQRT_LAST) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.v;
      root <= 64'd0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (running) begin
      if (fits) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign rsp.done = done;
  assign rsp.root = root[31:0];

endmodule

/* hw/rtl/csde_back.sv */
// ----------------------------------------------------------------------------
// csde_back
// Carries out queued items: loads start state, or runs one Euler-Maruyama
// step through the shared multiplier and square root, and registers results.
// ----------------------------------------------------------------------------
module csde_back import csde_pkg::*; #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  csde_cfg_t      cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  csde_item_t     q_item,
  output csde_mul_req_t  mul_req,
  input  csde_mul_rsp_t  mul_rsp,
  output csde_sqrt_req_t sqrt_req,
  input  csde_sqrt_rsp_t sqrt_rsp,
  csde_res_if.source     res
);

  localparam logic signed [65:0] POS_MAX = (66'sd1 <<< (VALUE_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] POS_MIN = -POS_MAX - 66'sd1;
  localparam logic signed [65:0] OUT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] OUT_MIN = -66'sd2147483648;
  localparam logic signed [63:0] EIGHT_F = 64'sd8 <<< FRACTION_BITS;
  localparam logic [5:0]         SH_F    = 6'(FRACTION_BITS);
  localparam logic [5:0]         SH_F3   = 6'(FRACTION_BITS + 3);

  csde_state_t state;
  csde_state_t state_next;
  logic        issued;
  logic        op_done;

  logic signed [VALUE_WIDTH-1:0] x_pos;
  logic signed [VALUE_WIDTH-1:0] y_pos;
  logic [63:0]        gx0, gx1, gy0, gy1;
  logic               lane;
  logic signed [63:0] sqh, sqe;
  logic signed [63:0] bx, by, nx, ny, tmp, tx, ty;
  logic signed [63:0] a_val, xs, z, p;
  logic [31:0]        m;
  logic [23:0]        frac;
  logic [4:0]         e;
  logic [4:0]         cnt;
  logic [22:0]        phase;
  logic               out_valid;
  logic signed [31:0] out_x, out_y;

  logic signed [63:0] d;
  logic signed [63:0] kx, ky, sx, sy, ie, hh;
  logic [63:0]        s0, s1, rnd, s1x, ns0, ns1;
  logic [23:0]        v24;
  logic [4:0]         e_new;
  logic [63:0]        g_val;
  logic [21:0]        rq;
  logic signed [63:0] r;
  logic signed [63:0] sine;
  logic               out_free;

  function automatic logic signed [VALUE_WIDTH-1:0] clamp_pos(input logic signed [65:0] v);
    logic signed [65:0] c;
    c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
    return c[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] clamp_out(input logic signed [65:0] v);
    logic signed [65:0] c;
    c = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
    return c[31:0];
  endfunction

  assign op_done  = mul_rsp.done || sqrt_rsp.done;
  assign r        = mul_rsp.result;
  assign out_free = !out_valid || res.ready;

  assign d  = 64'(x_pos) - 64'(y_pos);
  assign kx = $signed({32'd0, cfg.kappa_x});
  assign ky = $signed({32'd0, cfg.kappa_y});
  assign sx = $signed({32'd0, cfg.sigma_x});
  assign sy = $signed({32'd0, cfg.sigma_y});
  assign ie = $signed({32'd0, cfg.inv_epsilon});
  assign hh = $signed({32'd0, cfg.step_h});

  // xoroshiro128+ of the current lane
  assign s0  = lane ? gy0 : gx0;
  assign s1  = lane ? gy1 : gx1;
  assign rnd = s0 + s1;
  assign s1x = s1 ^ s0;
  assign ns0 = {s0[8:0], s0[63:9]} ^ s1x ^ (s1x << 14);
  assign ns1 = {s1x[27:0], s1x[63:28]};
  assign v24 = {1'b0, rnd[22:0]} + 24'd1;

  always_comb begin
    e_new = 5'd0;
    for (int i = 1; i < 24; i++) begin
      if (v24[i]) begin
        e_new = 5'(i);
      end
    end
  end

  assign g_val = (64'd23 << 24) - {35'd0, e, frac};
  assign rq    = phase[21] ? (22'h200000 - {1'b0, phase[20:0]}) : {1'b0, phase[20:0]};

  always_comb begin
    if (r[63]) begin
      sine = 64'sd0;
    end else if (r > Q30_ONE) begin
      sine = Q30_ONE;
    end else begin
      sine = r;
    end
    if (phase[22]) begin
      sine = -sine;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.kind == ITEM_START) ? ST_OUT : ST_SQH;
        end
      end
      ST_SQH:  if (op_done) state_next = ST_SQE;
      ST_SQE:  if (op_done) state_next = ST_BX0;
      ST_BX0:  if (op_done) state_next = cfg.drift_mode ? ST_BX1 : ST_BY;
      ST_BX1:  if (op_done) state_next = ST_BX2;
      ST_BX2:  if (op_done) state_next = ST_BY;
      ST_BY:   if (op_done) state_next = ST_GEN;
      ST_GEN:  state_next = ST_LOG;
      ST_LOG:  if (op_done && (cnt == LOG_LAST)) state_next = ST_G;
      ST_G:    if (op_done) state_next = ST_ROOT;
      ST_ROOT: if (op_done) state_next = ST_Z;
      ST_Z:    if (op_done) state_next = ST_POLY;
      ST_POLY: if (op_done && (cnt == 5'd0)) state_next = ST_PX;
      ST_PX:   if (op_done) state_next = ST_N;
      ST_N:    if (op_done) state_next = lane ? ST_TX0 : ST_GEN;
      ST_TX0:  if (op_done) state_next = ST_TX1;
      ST_TX1:  if (op_done) state_next = ST_TX2;
      ST_TX2:  if (op_done) state_next = ST_TX3;
      ST_TX3:  if (op_done) state_next = ST_TX4;
      ST_TX4:  if (op_done) state_next = ST_TY0;
      ST_TY0:  if (op_done) state_next = ST_TY1;
      ST_TY1:  if (op_done) state_next = ST_TY2;
      ST_TY2:  if (op_done) state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    q_ready        = (state == ST_IDLE);
    mul_req.start  = 1'b0;
    mul_req.a      = 64'sd0;
    mul_req.b      = 64'sd0;
    mul_req.sh     = SH_Q30;
    sqrt_req.start = 1'b0;
    sqrt_req.v     = 64'd0;
    case (state)
      ST_SQH: begin
        sqrt_req.start = !issued;
        sqrt_req.v     = {cfg.step_h, 32'd0};
      end
      ST_SQE: begin
        sqrt_req.start = !issued;
        sqrt_req.v     = {32'd0, cfg.inv_epsilon} << FRACTION_BITS;
      end
      ST_ROOT: begin
        sqrt_req.start = !issued;
        sqrt_req.v     = 64'(tmp) << 24;
      end
      ST_BX0: begin
        mul_req.start = !issued;
        mul_req.a     = cfg.drift_mode ? d : kx;
        mul_req.b     = d;
        mul_req.sh    = SH_F;
      end
      ST_BX1: begin
        mul_req.start = !issued;
        mul_req.a     = d;
        mul_req.b     = (tmp <<< 1) - EIGHT_F;
        mul_req.sh    = SH_F;
      end
      ST_BX2: begin
        mul_req.start = !issued;
        mul_req.a     = kx;
        mul_req.b     = tmp;
        mul_req.sh    = SH_F3;
      end
      ST_BY: begin
        mul_req.start = !issued;
        mul_req.a     = ky;
        mul_req.b     = -d;
        mul_req.sh    = SH_F;
      end
      ST_LOG: begin
        mul_req.start = !issued;
        mul_req.a     = $signed({32'd0, m});
        mul_req.b     = $signed({32'd0, m});
      end
      ST_G: begin
        mul_req.start = !issued;
        mul_req.a     = $signed(g_val);
        mul_req.b     = TWO_LN2_Q30;
      end
      ST_Z: begin
        mul_req.start = !issued;
        mul_req.a     = xs;
        mul_req.b     = xs;
      end
      ST_POLY: begin
        mul_req.start = !issued;
        mul_req.a     = z;
        mul_req.b     = p;
      end
      ST_PX: begin
        mul_req.start = !issued;
        mul_req.a     = xs;
        mul_req.b     = p;
      end
      ST_N: begin
        mul_req.start = !issued;
        mul_req.a     = a_val;
        mul_req.b     = p;
      end
      ST_TX0: begin
        mul_req.start = !issued;
        mul_req.a     = ie;
        mul_req.b     = bx;
        mul_req.sh    = SH_F;
      end
      ST_TX1: begin
        mul_req.start = !issued;
        mul_req.a     = tmp;
        mul_req.b     = hh;
        mul_req.sh    = SH_Q32;
      end
      ST_TX2: begin
        mul_req.start = !issued;
        mul_req.a     = sx;
        mul_req.b     = sqe;
        mul_req.sh    = SH_F;
      end
      ST_TX3: begin
        mul_req.start = !issued;
        mul_req.a     = tmp;
        mul_req.b     = nx;
        mul_req.sh    = SH_Q24;
      end
      ST_TX4: begin
        mul_req.start = !issued;
        mul_req.a     = tmp;
        mul_req.b     = sqh;
        mul_req.sh    = SH_Q32;
      end
      ST_TY0: begin
        mul_req.start = !issued;
        mul_req.a     = by;
        mul_req.b     = hh;
        mul_req.sh    = SH_Q32;
      end
      ST_TY1: begin
        mul_req.start = !issued;
        mul_req.a     = sy;
        mul_req.b     = ny;
        mul_req.sh    = SH_Q24;
      end
      ST_TY2: begin
        mul_req.start = !issued;
        mul_req.a     = tmp;
        mul_req.b     = sqh;
        mul_req.sh    = SH_Q32;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued    <= 1'b0;
      out_valid <= 1'b0;
      lane      <= 1'b0;
      x_pos     <= '0;
      y_pos     <= '0;
      gx0       <= 64'd0;
      gx1       <= 64'd0;
      gy0       <= 64'd0;
      gy1       <= 64'd0;
    end else begin
      if (mul_req.start || sqrt_req.start) begin
        issued <= 1'b1;
      end else if (op_done) begin
        issued <= 1'b0;
      end
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid && (q_item.kind == ITEM_START)) begin
            x_pos <= clamp_pos(66'(q_item.start_x));
            y_pos <= clamp_pos(66'(q_item.start_y));
            gx0   <= q_item.gen_x_word0;
            gx1   <= q_item.gen_x_word1;
            gy0   <= q_item.gen_y_word0;
            gy1   <= q_item.gen_y_word1;
          end
          lane <= 1'b0;
        end
        ST_GEN: begin
          if (lane) begin
            gy0 <= ns0;
            gy1 <= ns1;
          end else begin
            gx0 <= ns0;
            gx1 <= ns1;
          end
        end
        ST_N: begin
          if (op_done) begin
            lane <= ~lane;
          end
        end
        ST_UPD: begin
          x_pos <= clamp_pos(66'(x_pos) + 66'(tx));
          y_pos <= clamp_pos(66'(y_pos) + 66'(ty));
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_SQH:  if (op_done) sqh <= $signed({32'd0, sqrt_rsp.root});
      ST_SQE:  if (op_done) sqe <= $signed({32'd0, sqrt_rsp.root});
      ST_BX0: begin
        if (op_done) begin
          if (cfg.drift_mode) begin
            tmp <= r;
          end else begin
            bx <= -r;
          end
        end
      end
      ST_BX1:  if (op_done) tmp <= r;
      ST_BX2:  if (op_done) bx <= -r;
      ST_BY:   if (op_done) by <= -r;
      ST_GEN: begin
        e     <= e_new;
        m     <= 32'(v24) << (5'd30 - e_new);
        phase <= rnd[54:32];
        frac  <= 24'd0;
        cnt   <= 5'd0;
      end
      ST_LOG: begin
        if (op_done) begin
          // one fraction bit of log2 per squaring
          if (r >= 64'sd2147483648) begin
            m    <= r[32:1];
            frac <= {frac[22:0], 1'b1};
          end else begin
            m    <= r[31:0];
            frac <= {frac[22:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
        end
      end
      ST_G:    if (op_done) tmp <= r;
      ST_ROOT: begin
        if (op_done) begin
          a_val <= $signed({32'd0, sqrt_rsp.root});
          xs    <= $signed({33'd0, rq, 9'd0});
        end
      end
      ST_Z: begin
        if (op_done) begin
          z   <= r;
          p   <= SIN_COEF[5];
          cnt <= POLY_TOP;
        end
      end
      ST_POLY: begin
        if (op_done) begin
          p   <= SIN_COEF[cnt[2:0]] + r;
          cnt <= cnt - 5'd1;
        end
      end
      ST_PX:   if (op_done) p <= sine;
      ST_N: begin
        if (op_done) begin
          if (lane) begin
            ny <= r;
          end else begin
            nx <= r;
          end
        end
      end
      ST_TX0:  if (op_done) tmp <= r;
      ST_TX1:  if (op_done) tx <= r;
      ST_TX2:  if (op_done) tmp <= r;
      ST_TX3:  if (op_done) tmp <= r;
      ST_TX4:  if (op_done) tx <= tx + r;
      ST_TY0:  if (op_done) ty <= r;
      ST_TY1:  if (op_done) tmp <= r;
      ST_TY2:  if (op_done) ty <= ty + r;
      ST_OUT: begin
        if (out_free) begin
          out_x <= clamp_out(66'(x_pos));
          out_y <= clamp_out(66'(y_pos));
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid = out_valid;
  assign res.x_out = out_x;
  assign res.y_out = out_y;

endmodule

/* hw/rtl/coupled_sde_euler_maruyama_step_core.sv */
// ----------------------------------------------------------------------------
// coupled_sde_euler_maruyama_step_core
// Fixed-point Euler-Maruyama stepper for a coupled pair with Box-Muller noise.
// ----------------------------------------------------------------------------
// A start item loads x, y and both xoroshiro128+ states and returns the loaded
// positions. A step item takes longer with double-well drift than with
// Ornstein-Uhlenbeck drift: all products go through one shared multiplier of
// four 32x32 partial products, and the 24 log2 squarings per normal dominate;
// the four square roots run in a one-bit-a-cycle unit of 32 iterations. Items
// queue in a two-entry front queue and a result waits in an output register,
// so the host can hand in the next item while the last result is still pending.
module coupled_sde_euler_maruyama_step_core import csde_pkg::*; #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  csde_cmd_if.sink   cmd,
  csde_res_if.source res,
  csde_cfg_if.sink   cfg
);

  csde_cfg_t      regs;
  logic           q_valid;
  logic           q_ready;
  csde_item_t     q_item;
  csde_mul_req_t  mul_req;
  csde_mul_rsp_t  mul_rsp;
  csde_sqrt_req_t sqrt_req;
  csde_sqrt_rsp_t sqrt_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kappa_x     <= RATE_RESET;
      regs.kappa_y     <= RATE_RESET;
      regs.sigma_x     <= RATE_RESET;
      regs.sigma_y     <= RATE_RESET;
      regs.inv_epsilon <= RATE_RESET;
      regs.step_h      <= STEP_H_RESET;
      regs.drift_mode  <= 1'b0;
    end else if (cfg.valid) begin
      case (csde_cfg_index_t'(cfg.index))
        CFG_KAPPA_X:     regs.kappa_x     <= cfg.data;
        CFG_KAPPA_Y:     regs.kappa_y     <= cfg.data;
        CFG_SIGMA_X:     regs.sigma_x     <= cfg.data;
        CFG_SIGMA_Y:     regs.sigma_y     <= cfg.data;
        CFG_INV_EPSILON: regs.inv_epsilon <= cfg.data;
        CFG_STEP_H:      regs.step_h      <= cfg.data;
        CFG_DRIFT_MODE:  regs.drift_mode  <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  csde_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  csde_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  csde_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  csde_back #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp),
    .sqrt_req (sqrt_req),
    .sqrt_rsp (sqrt_rsp),
    .res      (res)
  );

endmodule

/* tb/coupled_sde_euler_maruyama_step_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coupled_sde_euler_maruyama_step_core_tb
// Drives start and step items through the stepper under several register
// settings and idling patterns. Each accepted item is run through a
// fixed-point model of the noise generators and the drift update, and every
// returned position pair is compared in order against that prediction.
// ----------------------------------------------------------------------------
module coupled_sde_euler_maruyama_step_core_tb;
  import csde_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } position_pair_t;

  // predicted positions and generator states, plus the queue of pending pairs
  class sde_scoreboard;
    logic [63:0]        gen_x0, gen_x1, gen_y0, gen_y1;
    logic signed [63:0] pos_x, pos_y;
    csde_cfg_t          regs;
    position_pair_t     pending[$];
    int                 errors, checked, starts, steps;

    function new();
      gen_x0 = '0; gen_x1 = '0; gen_y0 = '0; gen_y1 = '0;
      pos_x = '0; pos_y = '0;
      regs = '{kappa_x: RATE_RESET, kappa_y: RATE_RESET, sigma_x: RATE_RESET,
               sigma_y: RATE_RESET, inv_epsilon: RATE_RESET,
               step_h: STEP_H_RESET, drift_mode: 1'b0};
    endfunction

    function void report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endfunction

    function void write_reg(csde_cfg_index_t idx, logic [31:0] data);
      case (idx)
        CFG_KAPPA_X:     regs.kappa_x = data;
        CFG_KAPPA_Y:     regs.kappa_y = data;
        CFG_SIGMA_X:     regs.sigma_x = data;
        CFG_SIGMA_Y:     regs.sigma_y = data;
        CFG_INV_EPSILON: regs.inv_epsilon = data;
        CFG_STEP_H:      regs.step_h = data;
        CFG_DRIFT_MODE:  regs.drift_mode = data[0];
        default: ;
      endcase
    endfunction

    // signed product, shifted, magnitude capped at 2^61, truncated toward zero
    function logic signed [63:0] mul_q(logic signed [63:0] a, logic signed [63:0] b, int sh);
      logic [63:0]  ma, mb, mag;
      logic [127:0] p;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      p = {64'b0, ma} * {64'b0, mb};
      p = p >> sh;
      if (p > {64'b0, PROD_LIMIT}) p = {64'b0, PROD_LIMIT};
      mag = p[63:0];
      return (a[63] ^ b[63]) ? -mag : mag;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic signed [63:0] quarter_sine(logic signed [63:0] t);
      logic signed [63:0] z, p;
      z = mul_q(t, t, 30);
      p = SIN_COEF[5];
      for (int i = 4; i >= 0; i--) p = SIN_COEF[i] + mul_q(z, p, 30);
      p = mul_q(t, p, 30);
      if (p < 0) return 0;
      if (p > Q30_ONE) return Q30_ONE;
      return p;
    endfunction

    // one xoroshiro128+ draw turned into a Box-Muller normal, Q24
    function logic signed [63:0] gauss(inout logic [63:0] s0, inout logic [63:0] s1);
      logic [63:0]        r, t, v, phase, m, frac, g, lg, amp, rq;
      logic signed [63:0] sn;
      int                 e;
      r = s0 + s1;
      t = s1 ^ s0;
      s0 = ((s0 << 55) | (s0 >> 9)) ^ t ^ (t << 14);
      s1 = (t << 36) | (t >> 28);
      v = {41'b0, r[22:0]} + 64'd1;
      phase = {41'b0, r[54:32]};
      e = 0;
      while ((v >> (e + 1)) != 0) e++;
      m = v << (30 - e);
      frac = '0;
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 64'd1;
        end
      end
      g = (64'd23 << 24) - ((64'(e) << 24) | frac);
      lg = (g * 64'(TWO_LN2_Q30)) >> 30;
      amp = root64(lg << 24);
      rq = phase & 64'h1f_ffff;
      if (phase[21]) rq = (64'd1 << 21) - rq;
      sn = quarter_sine(rq << 9);
      if (phase[22]) sn = -sn;
      return mul_q(amp, sn, 30);
    endfunction

    function void note_item(csde_item_t it);
      logic signed [63:0] x, y, d, bx, by, nx, ny, tx, ty, sqh, sqe, h, sq, inner, tt;
      logic signed [63:0] kx, ky, sx, sy, ie;
      if (it.kind == ITEM_START) begin
        starts++;
        pos_x = clamp32(64'(it.start_x));
        pos_y = clamp32(64'(it.start_y));
        gen_x0 = it.gen_x_word0; gen_x1 = it.gen_x_word1;
        gen_y0 = it.gen_y_word0; gen_y1 = it.gen_y_word1;
      end else begin
        steps++;
        kx = {32'b0, regs.kappa_x}; ky = {32'b0, regs.kappa_y};
        sx = {32'b0, regs.sigma_x}; sy = {32'b0, regs.sigma_y};
        ie = {32'b0, regs.inv_epsilon}; h = {32'b0, regs.step_h};
        x = pos_x; y = pos_y; d = x - y;
        sqh = root64({regs.step_h, 32'b0});
        sqe = root64({16'b0, regs.inv_epsilon, 16'b0});
        if (!regs.drift_mode) begin
          bx = -mul_q(kx, d, 16);
        end else begin
          sq = mul_q(d, d, 16);
          inner = 2 * sq - (64'sd8 << 16);
          tt = mul_q(d, inner, 16);
          bx = -mul_q(kx, tt, 19);
        end
        by = -mul_q(ky, y - x, 16);
        nx = gauss(gen_x0, gen_x1);
        ny = gauss(gen_y0, gen_y1);
        tx = mul_q(mul_q(ie, bx, 16), h, 32);
        tx += mul_q(mul_q(mul_q(sx, sqe, 16), nx, 24), sqh, 32);
        ty = mul_q(by, h, 32);
        ty += mul_q(mul_q(sy, ny, 24), sqh, 32);
        pos_x = clamp32(x + tx);
        pos_y = clamp32(y + ty);
      end
      pending.push_back('{x: pos_x[31:0], y: pos_y[31:0]});
    endfunction

    function void check(logic signed [31:0] xo, logic signed [31:0] yo);
      position_pair_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d", xo, yo));
        return;
      end
      want = pending.pop_front();
      if (xo !== want.x) report($sformatf("x_out %0d, predicted %0d", xo, want.x));
      if (yo !== want.y) report($sformatf("y_out %0d, predicted %0d", yo, want.y));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  csde_cmd_if cmd_bus();
  csde_res_if res_bus();
  csde_cfg_if cfg_bus();

  coupled_sde_euler_maruyama_step_core uut (
    .clk(clk), .rst(rst), .cmd(cmd_bus.sink), .res(res_bus.source), .cfg(cfg_bus.sink)
  );

  always #10 clk = ~clk;

  sde_scoreboard sb = new();
  int send_idle_pct, recv_stall_pct, rx_hold, cfg_writes;

  initial begin
    #(120_000_000);
    $display("coupled_sde_euler_maruyama_step_core_tb NOT OK");
    $finish;
  end

  // result side: check on handshake, then choose ready for the next edge
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) sb.check(res_bus.x_out, res_bus.y_out);
      if (rx_hold > 0) begin
        rx_hold--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(csde_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.opcode      <= it.kind;
    cmd_bus.start_x     <= it.start_x;
    cmd_bus.start_y     <= it.start_y;
    cmd_bus.gen_x_word0 <= it.gen_x_word0;
    cmd_bus.gen_x_word1 <= it.gen_x_word1;
    cmd_bus.gen_y_word0 <= it.gen_y_word0;
    cmd_bus.gen_y_word1 <= it.gen_y_word1;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_item(it);
  endtask

  // lower valid and hold until every predicted pair has come back
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // back-to-back writes keep valid high; write_all lowers it after the last
  task automatic write_reg(csde_cfg_index_t idx, logic [31:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic write_all(logic [31:0] kx, logic [31:0] ky, logic [31:0] sx,
                           logic [31:0] sy, logic [31:0] ie, logic [31:0] h, logic dm);
    drain();
    write_reg(CFG_KAPPA_X, kx);
    write_reg(CFG_KAPPA_Y, ky);
    write_reg(CFG_SIGMA_X, sx);
    write_reg(CFG_SIGMA_Y, sy);
    write_reg(CFG_INV_EPSILON, ie);
    write_reg(CFG_STEP_H, h);
    write_reg(CFG_DRIFT_MODE, {31'b0, dm});
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic csde_item_t make_start(logic signed [31:0] sx, logic signed [31:0] sy,
                                            logic [63:0] a, logic [63:0] b,
                                            logic [63:0] c, logic [63:0] d);
    return '{kind: ITEM_START, start_x: sx, start_y: sy,
             gen_x_word0: a, gen_x_word1: b, gen_y_word0: c, gen_y_word1: d};
  endfunction

  function automatic csde_item_t random_item(int start_pct);
    csde_item_t it;
    logic signed [31:0] sx, sy;
    if ($urandom_range(3) == 0) begin
      sx = $urandom; sy = $urandom;
    end else begin
      // mostly near the wells so the drift stays in range
      sx = 32'($urandom_range(1 << 20)) - 32'sd524288;
      sy = 32'($urandom_range(1 << 20)) - 32'sd524288;
    end
    it = make_start(sx, sy, rand64(), rand64(), rand64(), rand64());
    // a step ignores the payload, so keep it random too
    if ($urandom_range(99) >= start_pct) it.kind = ITEM_STEP;
    return it;
  endfunction

  task automatic step_once();
    csde_item_t it;
    it = random_item(0);
    send_item(it);
  endtask

  initial begin
    csde_item_t it;
    send_idle_pct = 0; recv_stall_pct = 0; rx_hold = 0; cfg_writes = 0;
    rst <= 1'b1;
    cmd_bus.valid <= 1'b0; cmd_bus.opcode <= ITEM_START;
    cmd_bus.start_x <= '0; cmd_bus.start_y <= '0;
    cmd_bus.gen_x_word0 <= '0; cmd_bus.gen_x_word1 <= '0;
    cmd_bus.gen_y_word0 <= '0; cmd_bus.gen_y_word1 <= '0;
    cfg_bus.valid <= 1'b0; cfg_bus.index <= CFG_KAPPA_X; cfg_bus.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // steps on the zero generators before any start
    step_once();
    step_once();
    // extreme positions, with all-ones and then all-zero generators
    send_item(make_start(32'sh7fff_ffff, -32'sh8000_0000, '1, '1, '1, '1));
    step_once();
    send_item(make_start(-32'sh8000_0000, 32'sh7fff_ffff, '0, '0, '0, '0));
    step_once();
    // low draw bits all ones: u0 of one, zero amplitude
    send_item(make_start(32'sh0001_0000, -32'sh0001_0000,
                         64'h0000_0000_007f_ffff, '0, 64'h0040_0000_007f_ffff, '0));
    step_once();
    // each sine quadrant, with the fold at its edge
    send_item(make_start(0, 0, 64'h0020_0000_0000_0000, '0, 64'h0060_0000_0000_1234, '0));
    step_once();
    send_item(make_start(0, 0, 64'h0040_0000_0000_0000, '0, 64'h001f_ffff_0000_0000, '0));
    step_once();
    // double well with default rates, and the all-zero register extreme
    write_all(RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET, STEP_H_RESET, 1'b1);
    send_item(make_start(32'sh0002_0000, -32'sh0001_8000, 64'd1, 64'd2, 64'd3, 64'd4));
    step_once();
    step_once();
    write_all('0, '0, '0, '0, '0, '0, 1'b0);
    send_item(make_start(32'sh0003_0000, 32'sh0000_8000, rand64(), rand64(), rand64(), rand64()));
    step_once();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_all(RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET,
                     STEP_H_RESET, 1'b0);
        1: write_all('1, '1, '1, '1, '1, '1, 1'b1);
        2: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     1'($urandom));
        3: write_all(32'h0002_0000, 32'h0000_4000, 32'h0000_2000, 32'h0000_1000,
                     32'h0004_0000, 32'd4294967, 1'b1);
        default: write_all($urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
                           $urandom_range(32'h0002_0000), $urandom_range(32'h0002_0000),
                           $urandom_range(32'h0010_0000), $urandom, 1'b0);
      endcase
      send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 22 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 22 : 0;
      if (ph == 0) begin
        // receiver held off while cheap start items pile up at the input
        rx_hold = 300;
        for (int i = 0; i < 8; i++) send_item(random_item(100));
        drain();
      end
      for (int i = 0; i < 385; i++) begin
        it = random_item(40);
        send_item(it);
        if (i == 200) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("predicted results never arrived");
    $display("Covered %0d start and %0d step items, %0d register writes, %0d results checked.",
             sb.starts, sb.steps, cfg_writes, sb.checked);
    $display("Ran OU and double-well drift at zero, maximum, reset and random settings.");
    if (sb.errors == 0) begin
      $display("coupled_sde_euler_maruyama_step_core_tb OK");
    end else begin
      $display("coupled_sde_euler_maruyama_step_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* coupled_sde_euler_maruyama_step_core.f */
hw/rtl/csde_pkg.sv
hw/rtl/csde_if.sv
hw/rtl/csde_front.sv
hw/rtl/csde_mul.sv
hw/rtl/csde_sqrt.sv
hw/rtl/csde_back.sv
hw/rtl/coupled_sde_euler_maruyama_step_core.sv
tb/coupled_sde_euler_maruyama_step_core_tb.sv
